// File: rtl/mvsb_pkg.sv
// Shared definitions for the masked vertical scroll blitter: request layout,
// action and register codes, reset values and the edge mask helper.
// No dependencies.
`default_nettype none

package mvsb_pkg;

    localparam int WORD_BITS = 16;
    localparam int ADDR_BITS = 16;
    localparam int REQ_BITS  = 96;

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_SCROLL = 2'd2;

    localparam logic [2:0] REG_WORDS_PER_LINE = 3'd0;
    localparam logic [2:0] REG_PLANE_COUNT    = 3'd1;
    localparam logic [2:0] REG_CLIP_LEFT      = 3'd2;
    localparam logic [2:0] REG_CLIP_TOP       = 3'd3;
    localparam logic [2:0] REG_CLIP_RIGHT     = 3'd4;
    localparam logic [2:0] REG_CLIP_BOTTOM    = 3'd5;

    localparam logic [12:0] RST_WORDS_PER_LINE = 13'd40;
    localparam logic [3:0]  RST_PLANE_COUNT    = 4'd1;
    localparam logic [11:0] RST_CLIP_LEFT      = 12'd0;
    localparam logic [11:0] RST_CLIP_TOP       = 12'd0;
    localparam logic [12:0] RST_CLIP_RIGHT     = 13'd640;
    localparam logic [12:0] RST_CLIP_BOTTOM    = 13'd400;

    // Request payload; the last member sits in the lowest bits.
    typedef struct packed {
        logic [1:0]  pad;
        logic [12:0] span_height;
        logic [12:0] span_width;
        logic [11:0] dest_row;
        logic [11:0] source_row;
        logic [11:0] column;
        logic [15:0] write_word;
        logic [15:0] word_address;
    } req_t;

    // MSB-first mask of count pixels starting at pixel first.
    function automatic logic [WORD_BITS-1:0] edge_mask(input logic [4:0] first,
                                                       input logic [4:0] count);
        logic [WORD_BITS:0] ones;
        logic [WORD_BITS:0] shifted;
        logic [4:0]         sh;
        ones    = (17'd1 << count) - 17'd1;
        sh      = 5'd16 - first - count;
        shifted = ones << sh;
        return shifted[WORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/masked_vertical_scroll_blit.sv
// A write gives its result in the cycle after the request; a read passes first through
// the read-out state. A scroll passes the clipping and set-up states, then moves each word
// by a memory read state and a merge-and-write state on the single frame store.
// One request is in work at a time; the next is taken once the result slot is free.
// Reset (rst_n, asynchronous, active low) clears control state and loads the default
// registers; the frame store holds no defined contents until written.
`default_nettype none

module masked_vertical_scroll_blit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // word_address, write_word, column, source_row, dest_row, span_width,
    // span_height, two zero bits
    input  wire logic [mvsb_pkg::REQ_BITS-1:0] s_tdata,
    // action
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // read_word
    output logic [mvsb_pkg::WORD_BITS-1:0]     m_tdata,
    // applied
    output logic                               m_tuser,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [12:0]                   cfg_data
);
    import mvsb_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RDOUT = 4'd1;
    localparam logic [3:0] ST_CLIPX = 4'd2;
    localparam logic [3:0] ST_CLIPT = 4'd3;
    localparam logic [3:0] ST_CLIPB = 4'd4;
    localparam logic [3:0] ST_SET1  = 4'd5;
    localparam logic [3:0] ST_SET2  = 4'd6;
    localparam logic [3:0] ST_SET3  = 4'd7;
    localparam logic [3:0] ST_MVRD  = 4'd8;
    localparam logic [3:0] ST_MVWR  = 4'd9;

    localparam logic [1:0] PH_LEFT  = 2'd0;
    localparam logic [1:0] PH_FULL  = 2'd1;
    localparam logic [1:0] PH_RIGHT = 2'd2;

    // Configuration registers
    logic [12:0] upl_reg;
    logic [3:0]  planes_reg;
    logic [11:0] cl_reg;
    logic [11:0] ct_reg;
    logic [12:0] cr_reg;
    logic [12:0] cb_reg;

    // Control and scroll working registers
    logic [3:0]  state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_word_reg, out_word_next;
    logic        out_applied_reg, out_applied_next;
    req_t        req_reg, req_next;
    logic [12:0] left_reg, left_next;
    logic [12:0] right_reg, right_next;
    logic signed [14:0] sy_reg, sy_next;
    logic signed [14:0] dy_reg, dy_next;
    logic signed [14:0] h_reg, h_next;
    logic        up_reg, up_next;
    logic [12:0] width_reg, width_next;
    logic [15:0] lmask_reg, lmask_next;
    logic [15:0] rmask_reg, rmask_next;
    logic [8:0]  full_reg, full_next;
    logic [11:0] gp_reg, gp_next;
    logic [14:0] srow_reg, srow_next;
    logic [14:0] drow_reg, drow_next;
    logic [15:0] sb_reg, sb_next;
    logic [15:0] db_reg, db_next;
    logic [15:0] off_reg, off_next;
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  pk_reg, pk_next;
    logic [8:0]  gc_reg, gc_next;
    logic [12:0] rows_reg, rows_next;

    // Frame store
    logic [WORD_BITS-1:0] frame_store [0:(1 << ADDR_BITS)-1];
    logic [WORD_BITS-1:0] rd_src_reg;
    logic [WORD_BITS-1:0] rd_dst_reg;
    logic [ADDR_BITS-1:0] rd_src_addr;
    logic [ADDR_BITS-1:0] rd_dst_addr;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    req_t        req_in;
    logic        in_accept;
    logic [15:0] cur_mask;
    logic [15:0] mv_src;
    logic [15:0] mv_dst;

    assign req_in    = req_t'(s_tdata);
    assign s_tready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_word_reg;
    assign m_tuser   = out_applied_reg;

    assign mv_src = sb_reg + off_reg;
    assign mv_dst = db_reg + off_reg;

    always_comb
    begin
        case (phase_reg)
            PH_LEFT:  cur_mask = lmask_reg;
            PH_RIGHT: cur_mask = rmask_reg;
            default:  cur_mask = 16'hFFFF;
        endcase
    end

    assign rd_src_addr = (state_reg == ST_IDLE) ? req_in.word_address : mv_src;
    assign rd_dst_addr = mv_dst;
    assign mem_we      = (in_accept && s_tuser == ACT_WRITE) || (state_reg == ST_MVWR);
    assign mem_waddr   = (state_reg == ST_MVWR) ? mv_dst : req_in.word_address;
    assign mem_wdata   = (state_reg == ST_MVWR)
                       ? ((rd_dst_reg & ~cur_mask) | (rd_src_reg & cur_mask))
                       : req_in.write_word;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_store[mem_waddr] <= mem_wdata;
        end
        rd_src_reg <= frame_store[rd_src_addr];
        rd_dst_reg <= frame_store[rd_dst_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upl_reg    <= RST_WORDS_PER_LINE;
            planes_reg <= RST_PLANE_COUNT;
            cl_reg     <= RST_CLIP_LEFT;
            ct_reg     <= RST_CLIP_TOP;
            cr_reg     <= RST_CLIP_RIGHT;
            cb_reg     <= RST_CLIP_BOTTOM;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WORDS_PER_LINE: upl_reg    <= cfg_data;
                REG_PLANE_COUNT:    planes_reg <= cfg_data[3:0];
                REG_CLIP_LEFT:      cl_reg     <= cfg_data[11:0];
                REG_CLIP_TOP:       ct_reg     <= cfg_data[11:0];
                REG_CLIP_RIGHT:     cr_reg     <= cfg_data;
                REG_CLIP_BOTTOM:    cb_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Combinational next-state logic of the request sequencer.
    always_comb
    begin
        logic [13:0]        rsum;
        logic [13:0]        rclip;
        logic [12:0]        lclip;
        logic signed [14:0] ct_s;
        logic signed [14:0] cb_s;
        logic signed [14:0] lim_s;
        logic signed [14:0] lim_d;
        logic signed [14:0] hmin;
        logic [4:0]         lbit;
        logic [4:0]         nfit;
        logic [28:0]        prod;
        logic [8:0]         full_c;
        logic [15:0]        upl16;
        logic               last_plane;
        logic               has_full;
        logic               has_right;

        state_next       = state_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_word_next    = out_word_reg;
        out_applied_next = out_applied_reg;
        req_next   = req_reg;
        left_next  = left_reg;
        right_next = right_reg;
        sy_next    = sy_reg;
        dy_next    = dy_reg;
        h_next     = h_reg;
        up_next    = up_reg;
        width_next = width_reg;
        lmask_next = lmask_reg;
        rmask_next = rmask_reg;
        full_next  = full_reg;
        gp_next    = gp_reg;
        srow_next  = srow_reg;
        drow_next  = drow_reg;
        sb_next    = sb_reg;
        db_next    = db_reg;
        off_next   = off_reg;
        phase_next = phase_reg;
        pk_next    = pk_reg;
        gc_next    = gc_reg;
        rows_next  = rows_reg;

        rsum  = {2'b00, req_reg.column} + {1'b0, req_reg.span_width};
        rclip = (rsum > {1'b0, cr_reg}) ? {1'b0, cr_reg} : rsum;
        lclip = (req_reg.column < cl_reg) ? {1'b0, cl_reg} : {1'b0, req_reg.column};
        ct_s  = $signed({3'b000, ct_reg});
        cb_s  = $signed({2'b00, cb_reg});
        lim_s = cb_s - sy_reg;
        lim_d = cb_s - dy_reg;
        hmin  = h_reg;
        if (lim_s < hmin)
        begin
            hmin = lim_s;
        end
        if (lim_d < hmin)
        begin
            hmin = lim_d;
        end
        lbit   = {1'b0, left_reg[3:0]};
        nfit   = ((5'd16 - lbit) > width_reg[4:0] && width_reg < 13'd16)
               ? width_reg[4:0] : (5'd16 - lbit);
        prod   = {1'b0, srow_reg} * {1'b0, upl_reg};
        full_c = width_reg[12:4];
        upl16  = {3'b000, upl_reg};
        last_plane = (pk_reg == planes_reg - 4'd1);
        has_full   = (full_reg != 9'd0);
        has_right  = (rmask_reg != 16'd0);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    req_next = req_in;
                    unique case (s_tuser)
                        ACT_WRITE:
                        begin
                            out_valid_next   = 1'b1;
                            out_word_next    = '0;
                            out_applied_next = 1'b1;
                        end
                        ACT_READ:
                        begin
                            state_next = ST_RDOUT;
                        end
                        ACT_SCROLL:
                        begin
                            state_next = ST_CLIPX;
                        end
                        default:
                        begin
                            out_valid_next   = 1'b1;
                            out_word_next    = '0;
                            out_applied_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_RDOUT:
            begin
                out_valid_next   = 1'b1;
                out_word_next    = rd_src_reg;
                out_applied_next = 1'b1;
                state_next       = ST_IDLE;
            end
            ST_CLIPX:
            begin
                left_next  = lclip;
                right_next = rclip[12:0];
                sy_next    = $signed({3'b000, req_reg.source_row});
                dy_next    = $signed({3'b000, req_reg.dest_row});
                h_next     = $signed({2'b00, req_reg.span_height});
                // Pull the source start down to the top clip edge.
                if ({3'b000, req_reg.source_row} < {3'b000, ct_reg})
                begin
                    sy_next = ct_s;
                    dy_next = $signed({3'b000, req_reg.dest_row})
                            + (ct_s - $signed({3'b000, req_reg.source_row}));
                    h_next  = $signed({2'b00, req_reg.span_height})
                            - (ct_s - $signed({3'b000, req_reg.source_row}));
                end
                if (req_reg.source_row == req_reg.dest_row || req_reg.span_width == 13'd0
                    || rclip <= {1'b0, lclip})
                begin
                    out_valid_next   = 1'b1;
                    out_word_next    = '0;
                    out_applied_next = 1'b0;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CLIPT;
                end
            end
            ST_CLIPT:
            begin
                if (dy_reg < ct_s)
                begin
                    dy_next = ct_s;
                    sy_next = sy_reg + (ct_s - dy_reg);
                    h_next  = h_reg - (ct_s - dy_reg);
                end
                state_next = ST_CLIPB;
            end
            ST_CLIPB:
            begin
                h_next     = hmin;
                state_next = ST_SET1;
            end
            ST_SET1:
            begin
                if (h_reg <= 15'sd0)
                begin
                    out_valid_next   = 1'b1;
                    out_word_next    = '0;
                    out_applied_next = 1'b0;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    up_next    = (dy_reg < sy_reg);
                    width_next = right_reg - left_reg;
                    if (dy_reg < sy_reg)
                    begin
                        srow_next = sy_reg;
                        drow_next = dy_reg;
                    end
                    else
                    begin
                        srow_next = sy_reg + h_reg - 15'sd1;
                        drow_next = dy_reg + h_reg - 15'sd1;
                    end
                    rows_next  = h_reg[12:0];
                    state_next = ST_SET2;
                end
            end
            ST_SET2:
            begin
                if (lbit != 5'd0)
                begin
                    lmask_next = edge_mask(lbit, nfit);
                    width_next = width_reg - {8'd0, nfit};
                end
                else
                begin
                    lmask_next = '0;
                end
                gp_next    = left_reg[11:4] * planes_reg;
                sb_next    = prod[15:0];
                srow_next  = drow_reg;
                state_next = ST_SET3;
            end
            ST_SET3:
            begin
                db_next    = prod[15:0] + {4'd0, gp_reg};
                sb_next    = sb_reg + {4'd0, gp_reg};
                rmask_next = (width_reg[3:0] != 4'd0)
                           ? edge_mask(5'd0, {1'b0, width_reg[3:0]}) : 16'd0;
                full_next  = full_c;
                gc_next    = full_c;
                off_next   = '0;
                pk_next    = '0;
                phase_next = (lmask_reg != 16'd0) ? PH_LEFT
                           : (full_c != 9'd0) ? PH_FULL : PH_RIGHT;
                if (planes_reg == 4'd0)
                begin
                    out_valid_next   = 1'b1;
                    out_word_next    = '0;
                    out_applied_next = 1'b1;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MVRD;
                end
            end
            ST_MVRD:
            begin
                state_next = ST_MVWR;
            end
            ST_MVWR:
            begin
                off_next   = off_reg + 16'd1;
                pk_next    = pk_reg + 4'd1;
                state_next = ST_MVRD;
                if (last_plane)
                begin
                    pk_next = '0;
                    if (phase_reg == PH_FULL && gc_reg != 9'd1)
                    begin
                        gc_next = gc_reg - 9'd1;
                    end
                    else if (phase_reg == PH_LEFT && has_full)
                    begin
                        phase_next = PH_FULL;
                    end
                    else if (phase_reg != PH_RIGHT && has_right)
                    begin
                        phase_next = PH_RIGHT;
                    end
                    else
                    begin
                        // End of a row: step both bases by one line.
                        off_next   = '0;
                        gc_next    = full_reg;
                        phase_next = (lmask_reg != 16'd0) ? PH_LEFT
                                   : has_full ? PH_FULL : PH_RIGHT;
                        rows_next  = rows_reg - 13'd1;
                        sb_next    = up_reg ? (sb_reg + upl16) : (sb_reg - upl16);
                        db_next    = up_reg ? (db_reg + upl16) : (db_reg - upl16);
                        if (rows_reg == 13'd1)
                        begin
                            out_valid_next   = 1'b1;
                            out_word_next    = '0;
                            out_applied_next = 1'b1;
                            state_next       = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg    <= out_word_next;
        out_applied_reg <= out_applied_next;
        req_reg   <= req_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        sy_reg    <= sy_next;
        dy_reg    <= dy_next;
        h_reg     <= h_next;
        up_reg    <= up_next;
        width_reg <= width_next;
        lmask_reg <= lmask_next;
        rmask_reg <= rmask_next;
        full_reg  <= full_next;
        gp_reg    <= gp_next;
        srow_reg  <= srow_next;
        drow_reg  <= drow_next;
        sb_reg    <= sb_next;
        db_reg    <= db_next;
        off_reg   <= off_next;
        phase_reg <= phase_next;
        pk_reg    <= pk_next;
        gc_reg    <= gc_next;
        rows_reg  <= rows_next;
    end

`ifndef NO_ASSERTIONS
    // The frame store is only written on a write request or in a merge cycle.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_IDLE || state_reg == ST_MVWR))
        else $error("frame store written outside a write or merge cycle");

    // A merge always follows its read cycle, so the read data belongs to this word.
    a_merge_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MVWR |-> $past(state_reg) == ST_MVRD)
        else $error("merge without a preceding read");

    // A request is only taken when the result slot is free or being emptied.
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (!out_valid_reg || m_tready))
        else $error("request taken while a result is stalled");

    // Word moves only happen with at least one plane configured.
    a_planes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MVRD |-> planes_reg != 4'd0)
        else $error("word move with no planes");
`endif

endmodule

`default_nettype wire
